FILE: hdl/rcfd_pkg.sv
`default_nettype none
package rcfd_pkg;

    // frame layout
    localparam int LEN_BYTE           = 1;
    localparam int TYPE_BYTE          = 2;
    localparam int PAYLOAD_FIRST_BYTE = 3;

    // packed channels
    localparam int NUM_CH       = 16;
    localparam int CH_BITS      = 11;
    localparam int CH_IDX_BITS  = $clog2(NUM_CH);
    localparam int ISSUE_BITS   = $clog2(NUM_CH + 1);
    localparam int US_BITS      = 12;
    localparam int PAYLOAD_BITS = NUM_CH * CH_BITS;
    localparam int PAYLOAD_BYTES = PAYLOAD_BITS / 8;
    localparam int PIDX_BITS    = $clog2(PAYLOAD_BYTES);

    localparam logic [CH_IDX_BITS-1:0] CH_THROTTLE   = CH_IDX_BITS'(2);
    localparam logic [CH_IDX_BITS-1:0] CH_ARM_SWITCH = CH_IDX_BITS'(4);
    localparam logic [CH_IDX_BITS-1:0] CH_CAL_SWITCH = CH_IDX_BITS'(8);
    localparam logic [CH_IDX_BITS-1:0] LAST_CH       = CH_IDX_BITS'(NUM_CH - 1);

    // microseconds = floor((1024*v + 1443204) / 1639), reciprocal is exact over the range
    localparam int NUM_BITS    = 22;
    localparam int PROD_BITS   = 2 * NUM_BITS;
    localparam int RECIP_SHIFT = 32;
    localparam logic [NUM_BITS-1:0] MICROS_OFFSET = 22'd1443204;
    localparam logic [NUM_BITS-1:0] RECIP_MULT    = 22'd2620481;

    // register map
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 12;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SYNC_FIRST    = 3'd0;
    localparam t_cfg_idx CFG_SYNC_SECOND   = 3'd1;
    localparam t_cfg_idx CFG_FRAME_TYPE    = 3'd2;
    localparam t_cfg_idx CFG_MIN_BYTES     = 3'd3;
    localparam t_cfg_idx CFG_THROTTLE_LOW  = 3'd4;
    localparam t_cfg_idx CFG_SWITCH_HIGH   = 3'd5;
    localparam t_cfg_idx CFG_SWITCH_LOW    = 3'd6;

    localparam logic [7:0]  RST_SYNC_FIRST   = 8'd200;
    localparam logic [7:0]  RST_SYNC_SECOND  = 8'd238;
    localparam logic [7:0]  RST_FRAME_TYPE   = 8'd22;
    localparam logic [7:0]  RST_MIN_BYTES    = 8'd24;
    localparam logic [11:0] RST_THROTTLE_LOW = 12'd1050;
    localparam logic [11:0] RST_SWITCH_HIGH  = 12'd2000;
    localparam logic [11:0] RST_SWITCH_LOW   = 12'd1500;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [7:0]  frame_type;
        logic [7:0]  min_bytes;
        logic [11:0] throttle_low;
        logic [11:0] switch_high;
        logic [11:0] switch_low;
    } t_cfg;

    typedef enum logic [1:0] {
        CMD_IDLE,
        CMD_FRAME,
        CMD_DECODE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                 kind;
        logic                      imu;
        logic [PAYLOAD_BITS-1:0]   payload;
    } t_cmd;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

endpackage
`default_nettype wire

FILE: hdl/rcfd_front.sv
`default_nettype none
module rcfd_front #(
    parameter int FRAME_BUFFER_BYTES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rcfd_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_sensor_ready,
    input  logic               i_q_full,
    output logic               o_push,
    output rcfd_pkg::t_cmd     o_cmd
);
    import rcfd_pkg::*;

    localparam int CNT_BITS = $clog2(FRAME_BUFFER_BYTES + 1);

    logic                 r_in_frame;
    logic [CNT_BITS-1:0]  r_count;
    logic [7:0]           r_len;
    logic [7:0]           r_type;
    logic [7:0]           r_data [PAYLOAD_BYTES];
    logic [7:0]           n_data [PAYLOAD_BYTES];

    logic                 accept;
    logic [CNT_BITS-1:0]  count_inc;
    logic [7:0]           len_eff;
    logic [7:0]           type_eff;
    logic                 wr_hit;
    logic [PIDX_BITS-1:0] wr_idx;
    logic                 complete;
    logic                 long_enough;
    logic                 decode;
    logic                 buf_full;
    logic                 is_sync;

    assign accept    = i_valid && !i_q_full;
    assign count_inc = r_count + CNT_BITS'(1);
    assign len_eff   = (r_count == CNT_BITS'(LEN_BYTE))  ? i_rx_byte : r_len;
    assign type_eff  = (r_count == CNT_BITS'(TYPE_BYTE)) ? i_rx_byte : r_type;
    assign wr_hit    = (r_count >= CNT_BITS'(PAYLOAD_FIRST_BYTE)) &&
                       (r_count <  CNT_BITS'(PAYLOAD_FIRST_BYTE + PAYLOAD_BYTES));
    assign wr_idx    = PIDX_BITS'(r_count - CNT_BITS'(PAYLOAD_FIRST_BYTE));
    assign complete  = (9'(count_inc) == ({1'b0, len_eff} + 9'd2));
    assign long_enough = (9'(count_inc) >= {1'b0, i_cfg.min_bytes});
    assign decode    = complete && long_enough && (type_eff == i_cfg.frame_type);
    assign buf_full  = (count_inc >= CNT_BITS'(FRAME_BUFFER_BYTES));
    assign is_sync   = (i_rx_byte == i_cfg.sync_first) || (i_rx_byte == i_cfg.sync_second);

    // payload snapshot includes the byte being taken now
    always_comb begin
        n_data = r_data;
        if (r_in_frame && wr_hit) begin
            n_data[wr_idx] = i_rx_byte;
        end
        for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            o_cmd.payload[k*8 +: 8] = n_data[k];
        end
        o_cmd.imu = i_sensor_ready;
        if (!r_in_frame) begin
            o_cmd.kind = CMD_IDLE;
        end else if (decode) begin
            o_cmd.kind = CMD_DECODE;
        end else begin
            o_cmd.kind = CMD_FRAME;
        end
    end

    assign o_push = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_count    <= '0;
            r_len      <= '0;
            r_type     <= '0;
            for (int k = 0; k < PAYLOAD_BYTES; k++) begin
                r_data[k] <= '0;
            end
        end else if (accept) begin
            if (!r_in_frame) begin
                if (is_sync) begin
                    r_in_frame <= 1'b1;
                    r_count    <= CNT_BITS'(1);
                end
            end else begin
                r_data <= n_data;
                if (r_count == CNT_BITS'(LEN_BYTE)) begin
                    r_len <= i_rx_byte;
                end
                if (r_count == CNT_BITS'(TYPE_BYTE)) begin
                    r_type <= i_rx_byte;
                end
                if (complete || buf_full) begin
                    r_in_frame <= 1'b0;
                    r_count    <= '0;
                end else begin
                    r_count <= count_inc;
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: hdl/rcfd_queue.sv
`default_nettype none
module rcfd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rcfd_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output rcfd_pkg::t_cmd  o_cmd,
    output logic            o_full,
    output logic            o_empty
);
    import rcfd_pkg::*;

    t_cmd                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_fill;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_fill == QCNT_BITS'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                       : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                       : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hdl/rcfd_back.sv
`default_nettype none
module rcfd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rcfd_pkg::t_cfg                i_cfg,
    input  logic                          i_q_empty,
    input  rcfd_pkg::t_cmd                i_cmd,
    output logic                          o_pop,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic                          o_channel_valid,
    output logic [rcfd_pkg::CH_IDX_BITS-1:0] o_channel_index,
    output logic [rcfd_pkg::US_BITS-1:0]  o_channel_value,
    output logic                          o_armed_flag,
    output logic                          o_calibration_flag,
    output logic                          o_arm_event,
    output logic                          o_last
);
    import rcfd_pkg::*;

    typedef enum logic [1:0] {
        S_WAIT,
        S_CONV,
        S_FLAGS,
        S_EMIT
    } t_state;

    t_state                  r_state;
    logic                    r_decoded;
    logic                    r_imu;
    logic [PAYLOAD_BITS-1:0] r_shift;
    logic [ISSUE_BITS-1:0]   r_issue_cnt;
    logic                    r_p1_v;
    logic [CH_IDX_BITS-1:0]  r_p1_idx;
    logic [NUM_BITS-1:0]     r_num;
    logic                    r_p2_v;
    logic [CH_IDX_BITS-1:0]  r_p2_idx;
    logic [PROD_BITS-1:0]    r_prod;
    logic [US_BITS-1:0]      r_store [NUM_CH];
    logic                    r_armed;
    logic                    r_cal;
    logic                    r_event;
    logic [CH_IDX_BITS-1:0]  r_emit_idx;

    logic                    r_out_valid;
    logic                    r_out_ch_valid;
    logic [CH_IDX_BITS-1:0]  r_out_index;
    logic [US_BITS-1:0]      r_out_value;
    logic                    r_out_armed;
    logic                    r_out_cal;
    logic                    r_out_event;
    logic                    r_out_last;

    logic                    issue;
    logic                    slot_free;
    logic                    emit;
    logic                    emit_last;
    logic                    thr_low;
    logic                    arm_sw_high;
    logic                    arm_sw_low;
    logic                    cal_sw_high;
    logic                    cal_hit;
    logic                    arm_hit;

    assign o_pop      = (r_state == S_WAIT) && !i_q_empty;
    assign issue      = (r_state == S_CONV) && (r_issue_cnt < ISSUE_BITS'(NUM_CH));
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign emit       = (r_state == S_EMIT) && slot_free;
    assign emit_last  = !r_decoded || (r_emit_idx == LAST_CH);

    assign thr_low     = r_store[CH_THROTTLE]   <  i_cfg.throttle_low;
    assign arm_sw_high = r_store[CH_ARM_SWITCH] == i_cfg.switch_high;
    assign arm_sw_low  = r_store[CH_ARM_SWITCH] <  i_cfg.switch_low;
    assign cal_sw_high = r_store[CH_CAL_SWITCH] == i_cfg.switch_high;
    assign cal_hit     = cal_sw_high && thr_low && !r_imu && arm_sw_low;
    assign arm_hit     = thr_low && arm_sw_high && r_imu && !r_armed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_WAIT;
            r_decoded      <= 1'b0;
            r_imu          <= 1'b0;
            r_shift        <= '0;
            r_issue_cnt    <= '0;
            r_p1_v         <= 1'b0;
            r_p1_idx       <= '0;
            r_num          <= '0;
            r_p2_v         <= 1'b0;
            r_p2_idx       <= '0;
            r_prod         <= '0;
            for (int k = 0; k < NUM_CH; k++) begin
                r_store[k] <= '0;
            end
            r_armed        <= 1'b1;
            r_cal          <= 1'b0;
            r_event        <= 1'b0;
            r_emit_idx     <= '0;
            r_out_valid    <= 1'b0;
            r_out_ch_valid <= 1'b0;
            r_out_index    <= '0;
            r_out_value    <= '0;
            r_out_armed    <= 1'b0;
            r_out_cal      <= 1'b0;
            r_out_event    <= 1'b0;
            r_out_last     <= 1'b0;
        end else begin
            // conversion pipe: numerator, then reciprocal product, then store
            r_p1_v <= issue;
            if (issue) begin
                r_p1_idx    <= r_issue_cnt[CH_IDX_BITS-1:0];
                r_num       <= NUM_BITS'({r_shift[CH_BITS-1:0], 10'b0}) + MICROS_OFFSET;
                r_shift     <= r_shift >> CH_BITS;
                r_issue_cnt <= r_issue_cnt + 1'b1;
            end
            r_p2_v   <= r_p1_v;
            r_p2_idx <= r_p1_idx;
            r_prod   <= PROD_BITS'(r_num) * PROD_BITS'(RECIP_MULT);
            if (r_p2_v) begin
                r_store[r_p2_idx] <= r_prod[RECIP_SHIFT +: US_BITS];
            end

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_WAIT: begin
                    if (!i_q_empty) begin
                        r_decoded   <= (i_cmd.kind == CMD_DECODE);
                        r_imu       <= i_cmd.imu;
                        r_shift     <= i_cmd.payload;
                        r_issue_cnt <= '0;
                        r_event     <= 1'b0;
                        r_emit_idx  <= '0;
                        unique case (i_cmd.kind)
                            CMD_IDLE:   r_state <= S_EMIT;
                            CMD_FRAME:  r_state <= S_FLAGS;
                            CMD_DECODE: r_state <= S_CONV;
                            default:    r_state <= S_EMIT;
                        endcase
                    end
                end
                S_CONV: begin
                    if (r_p2_v && (r_p2_idx == LAST_CH)) begin
                        r_state <= S_FLAGS;
                    end
                end
                S_FLAGS: begin
                    // flags look at the channel store after any decode of this byte
                    r_cal <= r_cal || cal_hit;
                    if (arm_hit) begin
                        r_armed <= 1'b1;
                        r_event <= 1'b1;
                    end else if (arm_sw_low) begin
                        r_armed <= 1'b0;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_out_ch_valid <= r_decoded;
                        r_out_index    <= r_decoded ? r_emit_idx : '0;
                        r_out_value    <= r_decoded ? r_store[r_emit_idx] : '0;
                        r_out_armed    <= r_armed;
                        r_out_cal      <= r_cal;
                        r_out_event    <= r_event;
                        r_out_last     <= emit_last;
                        if (emit_last) begin
                            r_state <= S_WAIT;
                        end else begin
                            r_emit_idx <= r_emit_idx + 1'b1;
                        end
                    end
                end
                default: r_state <= S_WAIT;
            endcase
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_channel_valid    = r_out_ch_valid;
    assign o_channel_index    = r_out_index;
    assign o_channel_value    = r_out_value;
    assign o_armed_flag       = r_out_armed;
    assign o_calibration_flag = r_out_cal;
    assign o_arm_event        = r_out_event;
    assign o_last             = r_out_last;

endmodule
`default_nettype wire

FILE: hdl/rc_serial_frame_channel_decoder.sv
// Packed RC channel frame decoder fed one serial byte per transfer.
// Input channel: i_in_valid / o_in_stall carry i_rx_byte with i_sensor_ready
// sampled alongside. Output channel: o_out_valid / i_out_stall carry one
// result per transfer; a byte completing a good channel frame gives sixteen
// results (channels 0..15, o_last on the final one), any other byte one
// result with o_channel_valid low and o_last high.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index
// picks the register, i_cfg_data the value, low bits kept.
// Flow: the front end pushes one command per accepted byte into the queue;
// the back end pops it, and for a decoding byte the sixteen channels issue
// one per cycle into the reciprocal multiplier pipe, the pipe drains, the
// flags update, then the sixteen results leave one per cycle through the
// output register while the receiver does not stall. An in-frame byte only
// updates the flags; a byte outside a frame goes straight to the output.
// Reset: configuration returns to defaults, decoder idle, buffer and
// channels zero, armed set, calibration clear.
// Receiver stall: the output register holds, the back end waits, the
// two-entry queue fills, then o_in_stall rises.
`default_nettype none
module rc_serial_frame_channel_decoder #(
    parameter int FRAME_BUFFER_BYTES = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rcfd_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [rcfd_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [7:0]                         i_rx_byte,
    input  logic                               i_sensor_ready,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_channel_valid,
    output logic [3:0]                         o_channel_index,
    output logic [11:0]                        o_channel_value,
    output logic                               o_armed_flag,
    output logic                               o_calibration_flag,
    output logic                               o_arm_event,
    output logic                               o_last
);
    import rcfd_pkg::*;

    t_cfg r_cfg;
    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic front_push;
    logic q_full;
    logic q_empty;
    logic back_pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first   <= RST_SYNC_FIRST;
            r_cfg.sync_second  <= RST_SYNC_SECOND;
            r_cfg.frame_type   <= RST_FRAME_TYPE;
            r_cfg.min_bytes    <= RST_MIN_BYTES;
            r_cfg.throttle_low <= RST_THROTTLE_LOW;
            r_cfg.switch_high  <= RST_SWITCH_HIGH;
            r_cfg.switch_low   <= RST_SWITCH_LOW;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SYNC_FIRST:   r_cfg.sync_first   <= i_cfg_data[7:0];
                CFG_SYNC_SECOND:  r_cfg.sync_second  <= i_cfg_data[7:0];
                CFG_FRAME_TYPE:   r_cfg.frame_type   <= i_cfg_data[7:0];
                CFG_MIN_BYTES:    r_cfg.min_bytes    <= i_cfg_data[7:0];
                CFG_THROTTLE_LOW: r_cfg.throttle_low <= i_cfg_data;
                CFG_SWITCH_HIGH:  r_cfg.switch_high  <= i_cfg_data;
                CFG_SWITCH_LOW:   r_cfg.switch_low   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rcfd_front #(
        .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_in_valid),
        .i_rx_byte      (i_rx_byte),
        .i_sensor_ready (i_sensor_ready),
        .i_q_full       (q_full),
        .o_push         (front_push),
        .o_cmd          (front_cmd)
    );

    rcfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (back_pop),
        .o_cmd   (queue_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    rcfd_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_q_empty          (q_empty),
        .i_cmd              (queue_cmd),
        .o_pop              (back_pop),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_channel_valid    (o_channel_valid),
        .o_channel_index    (o_channel_index),
        .o_channel_value    (o_channel_value),
        .o_armed_flag       (o_armed_flag),
        .o_calibration_flag (o_calibration_flag),
        .o_arm_event        (o_arm_event),
        .o_last             (o_last)
    );

endmodule
`default_nettype wire

FILE: hdl/rcfd_checker.sv
`default_nettype none
module rcfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_channel_valid,
    input logic [3:0]  o_channel_index,
    input logic [11:0] o_channel_value,
    input logic        o_armed_flag,
    input logic        o_arm_event,
    input logic        o_last
);

    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_channel_value) && $stable(o_channel_index) &&
            $stable(o_last))
        else $error("stalled result changed");

    // a byte with no decode gives a single blank result
    a_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_channel_valid |->
            o_channel_index == 4'd0 && o_channel_value == 12'd0 && o_last)
        else $error("blank result malformed");

    a_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_arm_event |-> o_armed_flag)
        else $error("arm pulse without armed state");

    // converted pulse width range, and last only on the top channel
    a_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_channel_valid |->
            o_channel_value >= 12'd880 && o_channel_value <= 12'd2159 &&
            (o_last == (o_channel_index == 4'd15)))
        else $error("channel result out of range or misframed");

endmodule

bind rc_serial_frame_channel_decoder rcfd_checker u_rcfd_checker (.*);
`default_nettype wire

FILE: tb/sv/rc_serial_frame_channel_decoder_tb.sv
`default_nettype none
module rc_serial_frame_channel_decoder_tb;
    import rcfd_pkg::*;

    localparam int BUF_BYTES     = 64;
    localparam int US_DIVISOR    = 1639;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 10;

    // how the sensor ready flag is driven across the bytes of one frame
    localparam int IMU_LOW       = 0;
    localparam int IMU_HIGH      = 1;
    localparam int IMU_RANDOM    = 2;
    localparam int IMU_LAST_HIGH = 3;

    typedef struct packed {
        logic        chan_valid;
        logic [3:0]  chan_index;
        logic [11:0] chan_us;
        logic        armed;
        logic        cal;
        logic        arm_ev;
        logic        last;
    } t_channel_result;

    logic                     i_clk;
    logic                     i_rst_n     = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data  = '0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_stall;
    logic [7:0]               i_rx_byte   = 8'h00;
    logic                     i_sensor_ready = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_channel_valid;
    logic [3:0]               o_channel_index;
    logic [11:0]              o_channel_value;
    logic                     o_armed_flag;
    logic                     o_calibration_flag;
    logic                     o_arm_event;
    logic                     o_last;

    rc_serial_frame_channel_decoder #(
        .FRAME_BUFFER_BYTES(BUF_BYTES)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_rx_byte          (i_rx_byte),
        .i_sensor_ready     (i_sensor_ready),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_channel_valid    (o_channel_valid),
        .o_channel_index    (o_channel_index),
        .o_channel_value    (o_channel_value),
        .o_armed_flag       (o_armed_flag),
        .o_calibration_flag (o_calibration_flag),
        .o_arm_event        (o_arm_event),
        .o_last             (o_last)
    );

    // decoder copy: registers and state
    logic [7:0]  cfg_sync_a, cfg_sync_b, cfg_type, cfg_min_len;
    logic [11:0] cfg_thr_low, cfg_sw_high, cfg_sw_low;
    logic [7:0]  frame_buf [BUF_BYTES];
    int unsigned rx_count;
    bit          in_frame;
    logic [11:0] ch_us [NUM_CH];
    bit          armed, cal_req;

    t_channel_result pending_results[$];
    logic [7:0]      frame_bytes[$];
    logic [10:0]     frame_raw [NUM_CH];

    bit          steady = 1'b0;
    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;
    int unsigned results_checked = 0;
    int unsigned frames_decoded = 0;
    int unsigned arm_events = 0;
    int unsigned settings_used = 1;
    int unsigned cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(99) < 31);
    end

    function automatic logic [11:0] raw_to_us(logic [10:0] raw);
        int unsigned num;
        num = 32'(raw) * 1024 + 32'(MICROS_OFFSET);
        return 12'(num / US_DIVISOR);
    endfunction

    function automatic logic [7:0] buf_byte(int unsigned i);
        return (i < BUF_BYTES) ? frame_buf[i] : 8'h00;
    endfunction

    function automatic void reset_model();
        cfg_sync_a  = RST_SYNC_FIRST;
        cfg_sync_b  = RST_SYNC_SECOND;
        cfg_type    = RST_FRAME_TYPE;
        cfg_min_len = RST_MIN_BYTES;
        cfg_thr_low = RST_THROTTLE_LOW;
        cfg_sw_high = RST_SWITCH_HIGH;
        cfg_sw_low  = RST_SWITCH_LOW;
        foreach (frame_buf[i]) frame_buf[i] = 8'h00;
        foreach (ch_us[i]) ch_us[i] = 12'd0;
        rx_count = 0;
        in_frame = 1'b0;
        armed    = 1'b1;
        cal_req  = 1'b0;
    endfunction

    function automatic bit unpack_channels(int unsigned len);
        int unsigned pos, bi;
        logic [23:0] bits;
        if (len < cfg_min_len) return 1'b0;
        if (buf_byte(TYPE_BYTE) != cfg_type) return 1'b0;
        for (int c = 0; c < NUM_CH; c++) begin
            pos  = c * CH_BITS;
            bi   = PAYLOAD_FIRST_BYTE + pos / 8;
            bits = {buf_byte(bi + 2), buf_byte(bi + 1), buf_byte(bi)};
            ch_us[c] = raw_to_us(11'(bits >> (pos % 8)));
        end
        return 1'b1;
    endfunction

    // advance the decoder copy by one byte and queue what it should emit
    function automatic void decode_rx_byte(logic [7:0] b, logic imu);
        bit done, ev;
        int n;
        t_channel_result r;
        done = 1'b0;
        ev   = 1'b0;
        if (!in_frame) begin
            if (b == cfg_sync_a || b == cfg_sync_b) begin
                frame_buf[0] = b;
                rx_count = 1;
                in_frame = 1'b1;
            end
        end else begin
            if (rx_count < BUF_BYTES) frame_buf[rx_count] = b;
            rx_count++;
            if (rx_count >= 2 && rx_count == int'(buf_byte(LEN_BYTE)) + 2) begin
                done = unpack_channels(rx_count);
                in_frame = 1'b0;
                rx_count = 0;
            end
            // buffer full without completion drops the frame
            if (rx_count >= BUF_BYTES) begin
                rx_count = 0;
                in_frame = 1'b0;
            end
            if (ch_us[CH_CAL_SWITCH] == cfg_sw_high && ch_us[CH_THROTTLE] < cfg_thr_low &&
                !imu && !cal_req && ch_us[CH_ARM_SWITCH] < cfg_sw_low)
                cal_req = 1'b1;
            if (ch_us[CH_THROTTLE] < cfg_thr_low && ch_us[CH_ARM_SWITCH] == cfg_sw_high &&
                imu && !armed) begin
                armed = 1'b1;
                ev = 1'b1;
            end else if (ch_us[CH_ARM_SWITCH] < cfg_sw_low) begin
                armed = 1'b0;
            end
        end
        if (done) frames_decoded++;
        n = done ? NUM_CH : 1;
        for (int k = 0; k < n; k++) begin
            r.chan_valid = done;
            r.chan_index = done ? 4'(k) : 4'd0;
            r.chan_us    = done ? ch_us[k] : 12'd0;
            r.armed      = armed;
            r.cal        = cal_req;
            r.arm_ev     = ev;
            r.last       = (k == n - 1);
            pending_results.push_back(r);
        end
    endfunction

    always @(posedge i_clk) begin
        t_channel_result got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_channel_valid, o_channel_index, o_channel_value, o_armed_flag,
                   o_calibration_flag, o_arm_event, o_last};
            results_checked++;
            if (got.arm_ev && got.last) arm_events++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"unexpected result: v=%0d idx=%0d us=%0d arm=%0d",
                              " cal=%0d ev=%0d last=%0d"},
                             got.chan_valid, got.chan_index, got.chan_us, got.armed,
                             got.cal, got.arm_ev, got.last);
            end else begin
                want = pending_results.pop_front();
                if (got.chan_valid !== want.chan_valid || got.chan_index !== want.chan_index ||
                    got.chan_us !== want.chan_us || got.armed !== want.armed ||
                    got.cal !== want.cal || got.arm_ev !== want.arm_ev ||
                    got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch on result %0d", results_checked);
                        $display("  expected v=%0d idx=%0d us=%0d arm=%0d cal=%0d ev=%0d last=%0d",
                                 want.chan_valid, want.chan_index, want.chan_us, want.armed,
                                 want.cal, want.arm_ev, want.last);
                        $display("  actual   v=%0d idx=%0d us=%0d arm=%0d cal=%0d ev=%0d last=%0d",
                                 got.chan_valid, got.chan_index, got.chan_us, got.armed,
                                 got.cal, got.arm_ev, got.last);
                    end
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic imu);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 31) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_rx_byte      <= b;
        i_sensor_ready <= imu;
        do @(posedge i_clk); while (o_in_stall);
        decode_rx_byte(b, imu);
        bytes_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [11:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SYNC_FIRST:   cfg_sync_a  = data[7:0];
            CFG_SYNC_SECOND:  cfg_sync_b  = data[7:0];
            CFG_FRAME_TYPE:   cfg_type    = data[7:0];
            CFG_MIN_BYTES:    cfg_min_len = data[7:0];
            CFG_THROTTLE_LOW: cfg_thr_low = data;
            CFG_SWITCH_HIGH:  cfg_sw_high = data;
            CFG_SWITCH_LOW:   cfg_sw_low  = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [11:0] sync_a, sync_b, kind, min_len,
                              thr_low, sw_high, sw_low);
        write_reg(CFG_SYNC_FIRST, sync_a);
        write_reg(CFG_SYNC_SECOND, sync_b);
        write_reg(CFG_FRAME_TYPE, kind);
        write_reg(CFG_MIN_BYTES, min_len);
        write_reg(CFG_THROTTLE_LOW, thr_low);
        write_reg(CFG_SWITCH_HIGH, sw_high);
        write_reg(CFG_SWITCH_LOW, sw_low);
        settings_used++;
    endtask

    // smallest raw value reaching the given pulse width
    function automatic logic [10:0] raw_for_us(logic [11:0] target);
        for (int v = 0; v < 2048; v++)
            if (raw_to_us(11'(v)) >= target) return 11'(v);
        return 11'h7FF;
    endfunction

    function automatic logic [10:0] raw_below(logic [11:0] limit);
        logic [10:0] top;
        top = raw_for_us(limit);
        if (top == 11'd0) return 11'($urandom_range(2047));
        return 11'($urandom_range(0, int'(top) - 1));
    endfunction

    // random channels, steered towards the arm and calibration conditions
    function automatic void fill_channels();
        for (int c = 0; c < NUM_CH; c++) frame_raw[c] = 11'($urandom_range(2047));
        if ($urandom_range(3) != 0) frame_raw[CH_THROTTLE] = raw_below(cfg_thr_low);
        case ($urandom_range(9))
            0, 1, 2, 3: frame_raw[CH_ARM_SWITCH] = raw_for_us(cfg_sw_high);
            4, 5, 6:    frame_raw[CH_ARM_SWITCH] = raw_below(cfg_sw_low);
            default: ;
        endcase
        if ($urandom_range(1) != 0) frame_raw[CH_CAL_SWITCH] = raw_for_us(cfg_sw_high);
    endfunction

    function automatic void build_frame(logic [7:0] sync, logic [7:0] len_byte,
                                        logic [7:0] kind);
        logic [PAYLOAD_BITS-1:0] payload;
        int total;
        for (int c = 0; c < NUM_CH; c++) payload[c*CH_BITS +: CH_BITS] = frame_raw[c];
        total = int'(len_byte) + 2;
        frame_bytes.delete();
        frame_bytes.push_back(sync);
        frame_bytes.push_back(len_byte);
        for (int i = TYPE_BYTE; i < total; i++) begin
            if (i == TYPE_BYTE)
                frame_bytes.push_back(kind);
            else if (i - PAYLOAD_FIRST_BYTE < PAYLOAD_BYTES)
                frame_bytes.push_back(payload[(i - PAYLOAD_FIRST_BYTE)*8 +: 8]);
            else
                frame_bytes.push_back(8'($urandom_range(255)));
        end
    endfunction

    // anything past a full buffer would be seen as idle bytes, so stop there
    task automatic send_frame(input int imu_mode);
        int n;
        logic imu;
        n = (frame_bytes.size() < BUF_BYTES) ? frame_bytes.size() : BUF_BYTES;
        for (int i = 0; i < n; i++) begin
            case (imu_mode)
                IMU_LOW:       imu = 1'b0;
                IMU_HIGH:      imu = 1'b1;
                IMU_LAST_HIGH: imu = (i == n - 1);
                default:       imu = 1'($urandom_range(1));
            endcase
            send_byte(frame_bytes[i], imu);
        end
    endtask

    task automatic run_traffic(input int n_bytes);
        int unsigned start;
        int pick, len_lo, n_noise;
        logic [7:0] nb, sync, len_byte, kind_byte;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            pick = $urandom_range(99);
            if (pick < 13) begin
                n_noise = $urandom_range(1, 3);
                repeat (n_noise) begin
                    nb = 8'($urandom_range(255));
                    if ($urandom_range(9) != 0)
                        while (nb == cfg_sync_a || nb == cfg_sync_b)
                            nb = 8'($urandom_range(255));
                    send_byte(nb, 1'($urandom_range(1)));
                end
            end else begin
                fill_channels();
                sync = ($urandom_range(1) != 0) ? cfg_sync_a : cfg_sync_b;
                len_lo = int'(cfg_min_len) - 2;
                if (len_lo < 0) len_lo = 0;
                if (len_lo > 60) len_lo = 22;
                len_byte  = 8'(len_lo + $urandom_range(2));
                kind_byte = cfg_type;
                if (pick < 25) begin
                    kind_byte = cfg_type + 8'd1;
                end else if (pick < 35) begin
                    len_byte = (len_lo > 0) ? 8'($urandom_range(len_lo - 1)) : 8'd0;
                end else if (pick < 40) begin
                    // completes exactly at the buffer end, or overflows it
                    if ($urandom_range(1) != 0)
                        len_byte = 8'(62 + $urandom_range(1));
                    else
                        len_byte = 8'($urandom_range(64, 255));
                end
                build_frame(sync, len_byte, kind_byte);
                send_frame($urandom_range(3));
            end
        end
    endtask

    task automatic test_idle_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h5A, 1'b1);
    endtask

    // first in-frame byte disarms, the closing byte re-arms with imu ready
    task automatic test_arming_frame();
        for (int c = 0; c < NUM_CH; c++) frame_raw[c] = (c % 2 != 0) ? 11'h7FF : 11'h000;
        frame_raw[CH_THROTTLE]   = 11'h000;
        frame_raw[CH_ARM_SWITCH] = raw_for_us(cfg_sw_high);
        frame_raw[CH_CAL_SWITCH] = raw_for_us(cfg_sw_high);
        build_frame(cfg_sync_a, 8'd24, cfg_type);
        send_frame(IMU_LAST_HIGH);
    endtask

    task automatic test_calibration_frame();
        for (int c = 0; c < NUM_CH; c++) frame_raw[c] = 11'($urandom_range(2047));
        frame_raw[CH_THROTTLE]   = 11'h000;
        frame_raw[CH_ARM_SWITCH] = 11'h000;
        frame_raw[CH_CAL_SWITCH] = raw_for_us(cfg_sw_high);
        build_frame(cfg_sync_b, 8'd24, cfg_type);
        send_frame(IMU_LOW);
    endtask

    task automatic test_rejected_frames();
        fill_channels();
        build_frame(cfg_sync_a, 8'd0, cfg_type);
        send_frame(IMU_RANDOM);
        build_frame(cfg_sync_b, 8'd5, cfg_type);
        send_frame(IMU_HIGH);
    endtask

    task automatic test_buffer_overflow();
        fill_channels();
        build_frame(cfg_sync_a, 8'd63, cfg_type);
        send_frame(IMU_RANDOM);
    endtask

    // a short frame of the wrong type is dropped, then a short frame decodes with bytes left over from earlier frames
    task automatic test_short_frames();
        settle();
        write_reg(CFG_MIN_BYTES, 12'd4);
        fill_channels();
        build_frame(cfg_sync_a, 8'd4, cfg_type ^ 8'h01);
        send_frame(IMU_RANDOM);
        fill_channels();
        build_frame(cfg_sync_b, 8'd3, cfg_type);
        send_frame(IMU_RANDOM);
    endtask

    task automatic test_default_traffic();
        settle();
        set_config({4'hA, RST_SYNC_FIRST}, {4'h5, RST_SYNC_SECOND}, {4'hF, RST_FRAME_TYPE},
                   {4'h3, RST_MIN_BYTES}, RST_THROTTLE_LOW, RST_SWITCH_HIGH, RST_SWITCH_LOW);
        run_traffic(20);
    endtask

    task automatic test_extreme_settings();
        settle();
        set_config(12'hF00, 12'hFFF, 12'h000, 12'h000, 12'hFFF, 12'd880, 12'hFFF);
        run_traffic(10);
    endtask

    // nothing can decode here: min length beyond the buffer, nothing below zero
    task automatic test_closed_settings();
        settle();
        set_config(12'h0C8, 12'h0C8, 12'h0FF, 12'h0FF, 12'h000, 12'hFFF, 12'h000);
        run_traffic(5);
    endtask

    task automatic test_random_settings();
        settle();
        set_config(12'($urandom_range(4095)), 12'($urandom_range(4095)),
                   12'($urandom_range(4095)), 12'($urandom_range(0, 30)),
                   12'($urandom_range(900, 2200)), 12'($urandom_range(880, 2159)),
                   12'($urandom_range(900, 2200)));
        run_traffic(10);
    endtask

    task automatic test_steady_traffic();
        settle();
        steady = 1'b1;
        set_config(RST_SYNC_FIRST, RST_SYNC_SECOND, RST_FRAME_TYPE, 12'd6,
                   RST_THROTTLE_LOW, RST_SWITCH_HIGH, RST_SWITCH_LOW);
        run_traffic(30);
        settle();
        steady = 1'b0;
    endtask

    initial begin
        reset_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_bytes();
        test_arming_frame();
        test_calibration_frame();
        test_rejected_frames();
        test_buffer_overflow();
        test_short_frames();
        test_default_traffic();
        test_extreme_settings();
        test_closed_settings();
        test_random_settings();
        test_steady_traffic();
        settle();
        if (pending_results.size() != 0) begin
            $display("%0d expected results never arrived", pending_results.size());
            mismatches += pending_results.size();
        end
        $display("run: %0d bytes over %0d register settings, %0d result transfers checked",
                 bytes_sent, settings_used, results_checked);
        $display("run: %0d frames decoded, %0d arm events, calibration raised %0d, %0d mismatches",
                 frames_decoded, arm_events, cal_req, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
